### hw/rtl/abrp_pkg.sv
`default_nettype none
package abrp_pkg;

  localparam logic [7:0] KIND_ABS32    = 8'd2;
  localparam logic [7:0] KIND_TARGET1  = 8'd38;
  localparam logic [7:0] KIND_THM_CALL = 8'd10;
  localparam logic [7:0] KIND_CALL     = 8'd28;
  localparam logic [7:0] KIND_JUMP24   = 8'd29;

  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_HALF     = 4'd1;
  localparam logic [3:0] ERR_WORD     = 4'd2;
  localparam logic [3:0] ERR_T2A_STUB = 4'd3;
  localparam logic [3:0] ERR_NOLINK   = 4'd4;
  localparam logic [3:0] ERR_A2T_STUB = 4'd5;
  localparam logic [3:0] ERR_COND     = 4'd6;
  localparam logic [3:0] ERR_RANGE    = 4'd7;
  localparam logic [3:0] ERR_UNKNOWN  = 4'd8;

  localparam logic [3:0] COND_ALWAYS   = 4'hE;
  // upper five bits of the BLX second halfword (0xE800)
  localparam logic [4:0] THM_BLX_HI    = 5'b11101;
  // upper seven bits of the ARM BLX immediate word (0xFA000000)
  localparam logic [6:0] ARM_BLX_HI    = 7'b1111101;

  typedef enum logic [3:0] {
    CLS_DATA  = 4'b0001,
    CLS_THUMB = 4'b0010,
    CLS_ARM   = 4'b0100,
    CLS_NONE  = 4'b1000
  } rel_class_t;

  // after decode: base + addend done, place still to subtract
  typedef struct packed {
    rel_class_t  cls;
    logic        tbit;
    logic [31:0] op;
    logic [31:0] sum;
    logic [31:0] place;
    logic [3:0]  err;
  } dec_stage_t;

  // after subtract: final branch value
  typedef struct packed {
    rel_class_t  cls;
    logic        tbit;
    logic [31:0] op;
    logic [31:0] value;
    logic [3:0]  err;
  } sum_stage_t;

endpackage
`default_nettype wire

### hw/rtl/abrp_decode.sv
`default_nettype none
module abrp_decode import abrp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [7:0]  kind,
  input  wire logic [31:0] opcode_word,
  input  wire logic [31:0] target_address,
  input  wire logic [31:0] place_offset,
  input  wire logic        target_is_function,
  input  wire logic        target_thumb_bit,
  input  wire logic        blx_en,
  output logic             out_valid,
  output dec_stage_t       out_data
);

  dec_stage_t d_next;
  logic [31:0] addend;
  logic        tbit;
  logic        is_jump;

  always_comb begin
    tbit    = target_is_function & target_thumb_bit;
    is_jump = (kind == KIND_JUMP24);
    addend  = 32'd0;
    d_next.cls   = CLS_NONE;
    d_next.err   = ERR_UNKNOWN;
    d_next.place = place_offset;
    case (kind)
      KIND_ABS32, KIND_TARGET1: begin
        d_next.cls   = CLS_DATA;
        d_next.err   = ERR_OK;
        d_next.place = 32'd0;
        addend       = opcode_word;
      end
      KIND_THM_CALL: begin
        d_next.cls = CLS_THUMB;
        addend = {{9{opcode_word[10]}}, opcode_word[10:0], opcode_word[26:16], 1'b0};
        if (tbit) begin
          d_next.err = target_address[0] ? ERR_HALF : ERR_OK;
        end else if (!blx_en) begin
          d_next.err = ERR_T2A_STUB;
        end else begin
          d_next.err = (target_address[1:0] != 2'b00) ? ERR_WORD : ERR_OK;
        end
      end
      KIND_CALL, KIND_JUMP24: begin
        d_next.cls = CLS_ARM;
        addend = {{6{opcode_word[23]}}, opcode_word[23:0], 2'b00};
        if (tbit) begin
          if (target_address[0])                   d_next.err = ERR_HALF;
          else if (is_jump)                        d_next.err = ERR_NOLINK;
          else if (!blx_en)                        d_next.err = ERR_A2T_STUB;
          else if (opcode_word[31:28] != COND_ALWAYS) d_next.err = ERR_COND;
          else                                     d_next.err = ERR_OK;
        end else begin
          d_next.err = (target_address[1:0] != 2'b00) ? ERR_WORD : ERR_OK;
        end
      end
      default: begin
        d_next.cls = CLS_NONE;
      end
    endcase
    d_next.tbit = tbit;
    d_next.op   = opcode_word;
    d_next.sum  = target_address + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= d_next;
  end

endmodule
`default_nettype wire

### hw/rtl/abrp_sum.sv
`default_nettype none
module abrp_sum import abrp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire dec_stage_t  in_data,
  output logic             out_valid,
  output sum_stage_t       out_data
);

  sum_stage_t s_next;

  always_comb begin
    s_next.cls   = in_data.cls;
    s_next.tbit  = in_data.tbit;
    s_next.op    = in_data.op;
    s_next.err   = in_data.err;
    s_next.value = in_data.sum - in_data.place;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= s_next;
  end

endmodule
`default_nettype wire

### hw/rtl/abrp_encode.sv
`default_nettype none
module abrp_encode import abrp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire sum_stage_t  in_data,
  output logic             done,
  output logic [31:0]      patched_opcode,
  output logic [3:0]       error_code
);

  logic [31:0] res_next;
  logic [3:0]  err_next;
  logic        thm_in_range;
  logic        arm_in_range;
  logic [4:0]  second_hi;
  logic [7:0]  arm_hi;
  logic [31:0] v;

  // |value| < 2^22 and |value| < 2^25 (most negative value is out)
  always_comb begin
    v = in_data.value;
    thm_in_range = (v[31:22] == '0) || ((v[31:22] == '1) && (v[21:0] != '0));
    arm_in_range = (v[31:25] == '0) || ((v[31:25] == '1) && (v[24:0] != '0));
    second_hi = in_data.tbit ? in_data.op[31:27] : THM_BLX_HI;
    arm_hi    = in_data.tbit ? {ARM_BLX_HI, v[1]} : in_data.op[31:24];
    res_next  = in_data.op;
    err_next  = in_data.err;
    case (in_data.cls)
      CLS_DATA: begin
        res_next = {v[31:1], v[0] | in_data.tbit};
      end
      CLS_THUMB: begin
        if (in_data.err == ERR_OK && !thm_in_range) err_next = ERR_RANGE;
        if (err_next == ERR_OK) begin
          res_next = {second_hi, v[11:1], in_data.op[15:11], v[22:12]};
        end
      end
      CLS_ARM: begin
        if (in_data.err == ERR_OK && !arm_in_range) err_next = ERR_RANGE;
        if (err_next == ERR_OK) begin
          res_next = {arm_hi, v[25:2]};
        end
      end
      default: begin
        res_next = in_data.op;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    patched_opcode <= res_next;
    error_code     <= err_next;
  end

endmodule
`default_nettype wire

### hw/rtl/arm_branch_relocation_patcher_unit.sv
// ARM branch relocation patcher.
// Request channel: drive kind, opcode_word, target_address, place_offset,
//   target_is_function and target_thumb_bit with start high; the request is
//   taken at the rising edge where start is high and busy is low. busy is
//   tied low: a new request can be taken every cycle.
// Result channel: done is high for exactly one cycle with patched_opcode and
//   error_code; the receiver must take it then, it cannot hold results off.
// Pipeline: a request taken at a rising edge passes three register stages
//   (decode and base+addend add, place subtract, range check and re-encode)
//   before its result shows on done. Throughput: one request per cycle.
// Config: cfg_write with cfg_data sets blx_capable_core; write it only while
//   no request is in flight.
// Reset (rst, synchronous, active high): clears the stage valid bits and
//   blx_capable_core; requests in flight are dropped, no done follows.
`default_nettype none
module arm_branch_relocation_patcher_unit import abrp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  kind,
  input  wire logic [31:0] opcode_word,
  input  wire logic [31:0] target_address,
  input  wire logic [31:0] place_offset,
  input  wire logic        target_is_function,
  input  wire logic        target_thumb_bit,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  output logic             done,
  output logic [31:0]      patched_opcode,
  output logic [3:0]       error_code
);

  logic       blx_capable_core;
  logic       dec_valid;
  dec_stage_t dec_data;
  logic       sum_valid;
  sum_stage_t sum_data;

  // pipeline never stalls: results are pushed out unconditionally
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blx_capable_core <= 1'b0;
    end else if (cfg_write) begin
      blx_capable_core <= cfg_data;
    end
  end

  // stage 1: classify, pre-range checks, target + addend
  abrp_decode u_decode (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (start & ~busy),
    .kind               (kind),
    .opcode_word        (opcode_word),
    .target_address     (target_address),
    .place_offset       (place_offset),
    .target_is_function (target_is_function),
    .target_thumb_bit   (target_thumb_bit),
    .blx_en             (blx_capable_core),
    .out_valid          (dec_valid),
    .out_data           (dec_data)
  );

  // stage 2: subtract place to form the branch value
  abrp_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_data   (dec_data),
    .out_valid (sum_valid),
    .out_data  (sum_data)
  );

  // stage 3: range check, re-encode, output register
  abrp_encode u_encode (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (sum_valid),
    .in_data        (sum_data),
    .done           (done),
    .patched_opcode (patched_opcode),
    .error_code     (error_code)
  );

endmodule
`default_nettype wire
